@@ hw/rtl/ubs_pkg.sv @@
package ubs_pkg;

  // key width, fixed by the item format
  localparam int unsigned KEY_W = 32;

  // default number of keys one set may hold
  localparam int unsigned CAPACITY_DEF = 64;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_DRAIN,
    ST_FLUSH,
    ST_OUT
  } ubs_state_e;

  // per-state controls from the sequencer
  typedef struct packed {
    logic in_ready;
    logic rd_pass;
    logic wr_carry;
    logic out_mode;
  } ubs_ctrl_t;

endpackage

@@ hw/rtl/ubs_ram.sv @@
module ubs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hw/rtl/unsigned_key_bitonic_sorter_core.sv @@
// Sorts a set of 32-bit keys into ascending order, comparing raw bits as
// unsigned integers.
// Input channel: key_i and last_i, one key per beat, taken when in_valid_i is
// high and in_stall_o is low. A beat with last_i high, or the beat that fills
// the store to CAPACITY keys, closes the set.
// Output channel: sorted_key_o and final_res_o, one key per beat in ascending
// order, final_res_o high on the largest key; the receiver holds a beat with
// out_stall_i and the beat stays unchanged until taken.
// Operation: keys are stored one per cycle while the input is not stalled.
// The sort runs bubble passes over the key memory, one read and one write per
// cycle; passes shrink by one key each, and sorting stops after the first
// pass without an exchange, so an already sorted set takes one pass. The
// single read port then fetches one key at a time and issues the next read
// only once the previous key, read through the registered memory port, has
// reached the output register.
// The input is stalled from the closing beat until the last key has been
// read from memory. Reset empties the set and drops any pending output;
// memory contents need no clearing.
module unsigned_key_bitonic_sorter_core #(
  parameter int unsigned CAPACITY = ubs_pkg::CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ubs_pkg::KEY_W-1:0] key_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ubs_pkg::KEY_W-1:0] sorted_key_o,
  output logic                     final_res_o
);
  import ubs_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [AW-1:0] FULL_IDX = AW'(CAPACITY - 1);
  localparam logic [AW-1:0] ONE_IDX  = AW'(1);

  ubs_state_e state_q, state_d;
  ubs_ctrl_t  ctrl;

  logic [AW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    top_q, top_d;
  logic [AW-1:0]    lim_q, lim_d;
  logic [AW-1:0]    rd_q, rd_d;
  logic             rv_q, rv_d;
  logic [AW-1:0]    pidx_q, pidx_d;
  logic [KEY_W-1:0] carry_q, carry_d;
  logic             swap_q, swap_d;
  logic [AW-1:0]    oidx_q, oidx_d;
  logic             pend_q, pend_d;
  logic             pfin_q, pfin_d;
  logic             ovld_q, ovld_d;
  logic [KEY_W-1:0] okey_q, okey_d;
  logic             ofin_q, ofin_d;

  logic             in_acc, close, issue;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [KEY_W-1:0] wdata, rdata;

  ubs_ram #(
    .WIDTH(KEY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // per-state controls
  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_LOAD:  ctrl.in_ready = 1'b1;
      ST_READ:  ctrl.rd_pass  = 1'b1;
      ST_DRAIN: ctrl = '0;
      ST_FLUSH: ctrl.wr_carry = 1'b1;
      ST_OUT:   ctrl.out_mode = 1'b1;
      default:  ctrl = '0;
    endcase
  end

  assign in_stall_o = !ctrl.in_ready;
  assign in_acc     = in_valid_i && ctrl.in_ready;
  assign close      = in_acc && (last_i || (cnt_q == FULL_IDX));
  assign issue      = ctrl.out_mode && !pend_q && (!ovld_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (close) begin
          state_d = (cnt_q == '0) ? ST_OUT : ST_READ;
        end
      end
      ST_READ: begin
        if (rd_q == lim_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_FLUSH;
      ST_FLUSH: begin
        state_d = (!swap_q || lim_q == ONE_IDX) ? ST_OUT : ST_READ;
      end
      ST_OUT: begin
        if (issue && oidx_q == top_q) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // datapath: store, compare-exchange and output fetch
  always_comb begin
    cnt_d   = cnt_q;
    top_d   = top_q;
    lim_d   = lim_q;
    rd_d    = rd_q;
    rv_d    = 1'b0;
    pidx_d  = pidx_q;
    carry_d = carry_q;
    swap_d  = swap_q;
    oidx_d  = oidx_q;
    pend_d  = 1'b0;
    pfin_d  = pfin_q;
    ovld_d  = ovld_q;
    okey_d  = okey_q;
    ofin_d  = ofin_q;
    we      = 1'b0;
    waddr   = cnt_q;
    wdata   = key_i;
    raddr   = rd_q;

    // key store
    if (in_acc) begin
      we    = 1'b1;
      cnt_d = cnt_q + ONE_IDX;
      if (close) begin
        cnt_d  = '0;
        top_d  = cnt_q;
        lim_d  = cnt_q;
        rd_d   = '0;
        swap_d = 1'b0;
        oidx_d = '0;
      end
    end

    // issue pass reads
    if (ctrl.rd_pass) begin
      rv_d   = 1'b1;
      pidx_d = rd_q;
      rd_d   = rd_q + ONE_IDX;
    end

    // returning read: keep the larger key, write back the smaller one
    if (rv_q) begin
      if (pidx_q == '0) begin
        carry_d = rdata;
      end else begin
        we    = 1'b1;
        waddr = pidx_q - ONE_IDX;
        if (carry_q > rdata) begin
          wdata  = rdata;
          swap_d = 1'b1;
        end else begin
          wdata   = carry_q;
          carry_d = rdata;
        end
      end
    end

    // end of pass: largest key lands at the top of the pass
    if (ctrl.wr_carry) begin
      we     = 1'b1;
      waddr  = lim_q;
      wdata  = carry_q;
      lim_d  = lim_q - ONE_IDX;
      rd_d   = '0;
      swap_d = 1'b0;
    end

    // output fetch
    if (ctrl.out_mode) begin
      raddr = oidx_q;
    end
    if (issue) begin
      pend_d = 1'b1;
      pfin_d = (oidx_q == top_q);
      oidx_d = oidx_q + ONE_IDX;
    end

    // output register
    if (ovld_q && !out_stall_i) begin
      ovld_d = 1'b0;
    end
    if (pend_q) begin
      ovld_d = 1'b1;
      okey_d = rdata;
      ofin_d = pfin_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      pend_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
      pend_q  <= pend_d;
      ovld_q  <= ovld_d;
    end
  end

  // payload and index registers
  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    lim_q   <= lim_d;
    rd_q    <= rd_d;
    pidx_q  <= pidx_d;
    carry_q <= carry_d;
    swap_q  <= swap_d;
    oidx_q  <= oidx_d;
    pfin_q  <= pfin_d;
    okey_q  <= okey_d;
    ofin_q  <= ofin_d;
  end

  assign out_valid_o  = ovld_q;
  assign sorted_key_o = okey_q;
  assign final_res_o  = ofin_q;

endmodule

@@ bench/sort_checker.sv @@
module sort_checker #(
  parameter int unsigned CAPACITY = ubs_pkg::CAPACITY_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [ubs_pkg::KEY_W-1:0] key_i,
  input  logic                      last_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [ubs_pkg::KEY_W-1:0] sorted_key_i,
  input  logic                      final_res_i,
  output int unsigned               fails_o,
  output int unsigned               pending_o
);

  // one predicted output beat
  typedef struct packed {
    logic [ubs_pkg::KEY_W-1:0] key;
    logic                      fin;
  } sorted_beat_t;

  sorted_beat_t              sorted_q[$];
  sorted_beat_t              due;
  logic [ubs_pkg::KEY_W-1:0] set_keys [CAPACITY];
  int unsigned               set_size;

  // order the collected set ascending and queue one beat per key
  task automatic close_set();
    logic [ubs_pkg::KEY_W-1:0] ordered [$];
    logic [ubs_pkg::KEY_W-1:0] v;
    sorted_beat_t              beat;
    int                        j;
    ordered = {};
    for (int i = 0; i < set_size; i++) begin
      v = set_keys[i];
      j = ordered.size();
      while (j > 0 && ordered[j-1] > v) j--;
      ordered.insert(j, v);
    end
    for (int i = 0; i < set_size; i++) begin
      beat.key = ordered[i];
      beat.fin = (i == set_size - 1);
      sorted_q.push_back(beat);
    end
    set_size = 0;
  endtask

  // watch both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size = 0;
      sorted_q.delete();
      fails_o = 0;
    end else begin
      // result beat against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (sorted_q.size() == 0) begin
          $error("unexpected result beat: sorted_key %h final_res %b",
                 sorted_key_i, final_res_i);
          fails_o++;
        end else begin
          due = sorted_q.pop_front();
          if (sorted_key_i !== due.key) begin
            $error("sorted_key mismatch: expected %h, actual %h", due.key, sorted_key_i);
            fails_o++;
          end
          if (final_res_i !== due.fin) begin
            $error("final_res mismatch: expected %b, actual %b", due.fin, final_res_i);
            fails_o++;
          end
        end
      end
      // key beat into the predicted set
      if (in_valid_i && !in_stall_i) begin
        set_keys[set_size] = key_i;
        set_size++;
        if (last_i || set_size == CAPACITY) close_set();
      end
    end
    pending_o = sorted_q.size();
  end

endmodule

@@ bench/tb_top.sv @@
module tb_top;

  import ubs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RANDOM_KEYS = 200;

  // kinds of key content in one set
  typedef enum int unsigned {
    KEYS_RANDOM,
    KEYS_FEW,
    KEYS_EXTREME,
    KEYS_FLOAT,
    KEYS_RISING,
    KEYS_FALLING
  } key_mix_e;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic             in_stall;
  logic [KEY_W-1:0] key;
  logic             last;
  logic             out_valid;
  logic             out_stall;
  logic [KEY_W-1:0] sorted_key;
  logic             final_res;
  int unsigned      fails;
  int unsigned      pending;
  int unsigned      max_gap = 16;
  int unsigned      cycles = 0;

  unsigned_key_bitonic_sorter_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .key_i        (key),
    .last_i       (last),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .sorted_key_o (sorted_key),
    .final_res_o  (final_res)
  );

  sort_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .key_i        (key),
    .last_i       (last),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .sorted_key_i (sorted_key),
    .final_res_i  (final_res),
    .fails_o      (fails),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stall before each result beat
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    @(negedge clk_i);
    forever begin
      hold = $urandom_range(0, max_gap);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid);
      @(negedge clk_i);
    end
  end

  function automatic logic [KEY_W-1:0] make_key(key_mix_e mix, int unsigned idx,
                                                logic [KEY_W-1:0] base);
    case (mix)
      KEYS_FEW: return $urandom_range(0, 7);
      KEYS_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return 32'h8000_0000;
          default: return 32'h7fff_ffff;
        endcase
      end
      // non-negative float bit patterns
      KEYS_FLOAT:   return {1'b0, 8'($urandom_range(100, 150)), 23'($urandom)};
      KEYS_RISING:  return base + idx * 3;
      KEYS_FALLING: return base - idx * 3;
      default:      return $urandom;
    endcase
  endfunction

  // one key beat, entered and left at a falling edge
  task automatic send_key(input logic [KEY_W-1:0] k, input logic l);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    key      <= k;
    last     <= l;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  task automatic send_set(input int unsigned n, input key_mix_e mix,
                          input logic [KEY_W-1:0] base, input logic with_last);
    for (int i = 0; i < n; i++) send_key(make_key(mix, i, base), with_last && (i == n - 1));
  endtask

  // sender idle until every predicted result has left
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // stimulus and verdict
  initial begin
    key_mix_e    mix;
    int unsigned set_len;
    int unsigned set_idx;
    int unsigned random_keys;
    logic        with_last;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    key      = '0;
    last     = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single-key sets at both extremes
    send_key(32'hffff_ffff, 1'b1);
    send_key(32'h0000_0000, 1'b1);
    // extremes in falling order
    send_key(32'hffff_ffff, 1'b0);
    send_key(32'h8000_0000, 1'b0);
    send_key(32'h7fff_ffff, 1'b0);
    send_key(32'h0000_0001, 1'b0);
    send_key(32'h0000_0000, 1'b1);
    // equal keys
    send_key(32'h0000_0005, 1'b0);
    send_key(32'h0000_0005, 1'b0);
    send_key(32'h0000_0005, 1'b1);
    send_key(32'h0000_0005, 1'b0);
    send_key(32'h0000_0003, 1'b0);
    send_key(32'h0000_0005, 1'b0);
    send_key(32'h0000_0003, 1'b1);
    // already in order
    send_key(32'h0000_0001, 1'b0);
    send_key(32'h0000_0002, 1'b0);
    send_key(32'h0000_0003, 1'b0);
    send_key(32'h0000_0004, 1'b1);
    wait_drained();

    // random sets; full sets close on capacity, with or without last
    set_idx     = 0;
    random_keys = 0;
    while (random_keys < RANDOM_KEYS) begin
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : 16;
      mix     = key_mix_e'($urandom_range(0, 5));
      if (set_idx == 0 || set_idx == 5 || $urandom_range(0, 19) == 0) begin
        set_len   = CAPACITY_DEF;
        with_last = (set_idx == 0) ? 1'b0 : 1'(set_idx == 5 || $urandom_range(0, 1) == 1);
      end else begin
        set_len   = ($urandom_range(0, 3) == 0) ? $urandom_range(21, 63) : $urandom_range(1, 20);
        with_last = 1'b1;
      end
      send_set(set_len, mix, $urandom, with_last);
      random_keys += set_len;
      // hold off until the block has emptied
      if (set_idx % 7 == 3) wait_drained();
      set_idx++;
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (50) @(negedge clk_i);
    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ubs_pkg.sv
hw/rtl/ubs_ram.sv
hw/rtl/unsigned_key_bitonic_sorter_core.sv
bench/sort_checker.sv
bench/tb_top.sv
